@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the BER REAL encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ber_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_pkg
// Types and constants shared by the BER REAL encoder modules.
// ----------------------------------------------------------------------------
package ber_pkg;

	localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

	localparam logic [7:0] OCT_NAN      = 8'h42;
	localparam logic [7:0] OCT_NEG_INF  = 8'h41;
	localparam logic [7:0] OCT_POS_INF  = 8'h40;
	localparam logic [7:0] OCT_NEG_ZERO = 8'h43;
	localparam logic [7:0] OCT_NONE     = 8'h00;

	localparam logic [7:0] HDR_BASE    = 8'h80;
	localparam logic [7:0] HDR_NEG     = 8'h40;
	localparam logic [7:0] HDR_TWO_EXP = 8'h01;

	// One classified item as handed from the front to the back.
	typedef struct packed {
		logic        special;  // single-octet encoding
		logic [7:0]  sbyte;    // octet for the single-octet case
		logic        empty;    // positive zero: no content octets
		logic        neg;
		logic        two_exp;  // exponent needs two octets
		logic [11:0] expo;     // final exponent, two's complement
		logic [2:0]  kept;     // mantissa octets, 1..7
		logic [55:0] mant;     // mantissa, first octet in the top byte
	} ber_desc_t;

	// Back-end sequencer phases.
	typedef enum logic [5:0] {
		P_IDLE  = 6'b000001,
		P_SPEC  = 6'b000010,
		P_HDR   = 6'b000100,
		P_EXPHI = 6'b001000,
		P_EXPLO = 6'b010000,
		P_MANT  = 6'b100000
	} ber_phase_t;

endpackage

@@ rtl/ber_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_front
// Accepts input items and classifies each into an encoding descriptor.
// ----------------------------------------------------------------------------
module ber_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [63:0]           value_bits,
	input  logic                  q_full,
	output logic                  push,
	output ber_pkg::ber_desc_t    desc
);

	logic        v_s1;
	logic [63:0] bits_s1;

	logic        neg;
	logic [10:0] bexp;
	logic [51:0] frac;
	logic [55:0] mant;
	logic [2:0]  tz;
	logic        found;
	logic [7:0]  lowbyte;
	logic [2:0]  sh;
	logic        sfound;
	logic signed [12:0] e_start;
	logic signed [12:0] e_final;

	assign busy = v_s1 & q_full;
	assign push = v_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (start && !busy) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			bits_s1 <= value_bits;
		end
	end

	assign neg  = bits_s1[63];
	assign bexp = bits_s1[62:52];
	assign frac = bits_s1[51:0];

	always_comb begin
		mant = {3'b000, (bexp != 11'd0), frac};

		// Count trailing zero octets; at least one octet is kept.
		tz    = 3'd0;
		found = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (!found && mant[8*i +: 8] == 8'h00) begin
				tz = tz + 3'd1;
			end else begin
				found = 1'b1;
			end
		end
		lowbyte = mant[{tz, 3'b000} +: 8];

		// Trailing zero bits of the lowest kept octet.
		sh     = 3'd0;
		sfound = 1'b0;
		for (int j = 0; j < 7; j++) begin
			if (!sfound && !lowbyte[j]) begin
				sh = sh + 3'd1;
			end else begin
				sfound = 1'b1;
			end
		end

		if (bexp == 11'd0) begin
			e_start = -13'sd1022;
		end else begin
			e_start = $signed({2'b00, bexp}) - 13'sd1023;
		end
		e_final = e_start + 13'sd4 - $signed({7'b0, 3'd7 - tz, 3'b000})
			+ $signed({10'b0, sh});

		desc.neg     = neg;
		desc.expo    = e_final[11:0];
		desc.two_exp = (e_final[11:7] != 5'b00000) && (e_final[11:7] != 5'b11111);
		desc.kept    = 3'd7 - tz;
		// Dropped low octets are zero, so the odd mantissa stays top-aligned.
		desc.mant    = mant >> sh;
		desc.special = 1'b0;
		desc.sbyte   = ber_pkg::OCT_NONE;
		desc.empty   = 1'b0;

		if (bexp == ber_pkg::EXP_ALL_ONES) begin
			desc.special = 1'b1;
			if (frac != 52'd0) begin
				desc.sbyte = ber_pkg::OCT_NAN;
			end else if (neg) begin
				desc.sbyte = ber_pkg::OCT_NEG_INF;
			end else begin
				desc.sbyte = ber_pkg::OCT_POS_INF;
			end
		end else if (bexp == 11'd0 && frac == 52'd0) begin
			desc.special = 1'b1;
			if (neg) begin
				desc.sbyte = ber_pkg::OCT_NEG_ZERO;
			end else begin
				desc.empty = 1'b1;
			end
		end
	end

endmodule

@@ rtl/ber_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_queue
// Small descriptor FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module ber_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ber_pkg::ber_desc_t wdata,
	input  logic               pop,
	output ber_pkg::ber_desc_t rdata,
	output logic               full,
	output logic               nonempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ber_pkg::ber_desc_t slots_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/ber_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_back
// Serializes one descriptor into content octets, one octet per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ber_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	input  ber_pkg::ber_desc_t q_head,
	output logic               pop,
	output logic               valid,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               empty_res
);

	ber_pkg::ber_phase_t phase_q;
	ber_pkg::ber_phase_t phase_nx;
	ber_pkg::ber_desc_t  cur_q;
	logic [2:0]          cnt_q;
	logic [55:0]         mant_q;

	logic        done_now;
	logic [7:0]  byte_nx;
	logic        last_nx;
	logic        empty_nx;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        empty_q;

	assign done_now = (phase_q == ber_pkg::P_SPEC) ||
		((phase_q == ber_pkg::P_MANT) && (cnt_q == 3'd1));
	assign pop = q_nonempty && ((phase_q == ber_pkg::P_IDLE) || done_now);

	always_comb begin
		phase_nx = phase_q;
		byte_nx  = 8'h00;
		last_nx  = 1'b0;
		empty_nx = 1'b0;
		case (phase_q)
			ber_pkg::P_SPEC: begin
				byte_nx  = cur_q.sbyte;
				last_nx  = 1'b1;
				empty_nx = cur_q.empty;
				phase_nx = ber_pkg::P_IDLE;
			end
			ber_pkg::P_HDR: begin
				byte_nx = ber_pkg::HDR_BASE
					| (cur_q.neg ? ber_pkg::HDR_NEG : 8'h00)
					| (cur_q.two_exp ? ber_pkg::HDR_TWO_EXP : 8'h00);
				phase_nx = cur_q.two_exp ? ber_pkg::P_EXPHI : ber_pkg::P_EXPLO;
			end
			ber_pkg::P_EXPHI: begin
				byte_nx  = {{4{cur_q.expo[11]}}, cur_q.expo[11:8]};
				phase_nx = ber_pkg::P_EXPLO;
			end
			ber_pkg::P_EXPLO: begin
				byte_nx  = cur_q.expo[7:0];
				phase_nx = ber_pkg::P_MANT;
			end
			ber_pkg::P_MANT: begin
				byte_nx  = mant_q[55:48];
				last_nx  = (cnt_q == 3'd1);
				phase_nx = (cnt_q == 3'd1) ? ber_pkg::P_IDLE : ber_pkg::P_MANT;
			end
			default: begin
				phase_nx = ber_pkg::P_IDLE;
			end
		endcase
		if (pop) begin
			phase_nx = q_head.special ? ber_pkg::P_SPEC : ber_pkg::P_HDR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ber_pkg::P_IDLE;
			valid_q <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			valid_q <= (phase_q != ber_pkg::P_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= q_head;
			cnt_q  <= q_head.kept;
			mant_q <= q_head.mant;
		end else if (phase_q == ber_pkg::P_MANT) begin
			cnt_q  <= cnt_q - 3'd1;
			mant_q <= {mant_q[47:0], 8'h00};
		end
		if (phase_q != ber_pkg::P_IDLE) begin
			byte_q  <= byte_nx;
			last_q  <= last_nx;
			empty_q <= empty_nx;
		end
	end

	assign valid     = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
	assign empty_res = empty_q;

	`ASSERT_IMPLY(a_empty_is_lone, clk, arst_n, valid_q && empty_q, last_q && (byte_q == 8'h00))
	`ASSERT_IMPLY(a_mant_count, clk, arst_n, phase_q == ber_pkg::P_MANT, cnt_q != 3'd0)
	`ASSERT_NEXT(a_spec_last, clk, arst_n, phase_q == ber_pkg::P_SPEC, valid_q && last_q)
	`ASSERT_IMPLY(a_pop_when_free, clk, arst_n, pop, (phase_q == ber_pkg::P_IDLE) || done_now)

endmodule

@@ rtl/double_to_ber_real_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_to_ber_real_encoder
// Encodes an IEEE binary64 pattern as BER REAL (base 2) content octets.
// ----------------------------------------------------------------------------
// Path: with an empty queue and an idle back end, the first octet of an
// item passes the input register, the queue slot, the back-end phase
// register and the output register before it is on the ports.
// Throughput: one octet per cycle; an item has 1 octet for special values
// and up to 10 otherwise.
// Reset: arst_n clears all control state; the receiver cannot stall output.
// ----------------------------------------------------------------------------
module double_to_ber_real_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value_bits,
	output logic        valid,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        empty_res
);

	// The front end registers each item and classifies it in the next cycle:
	// special values collapse to a single octet, finite values get their
	// trimmed, odd mantissa and adjusted exponent. The result is a descriptor
	// pushed into a short queue.
	ber_pkg::ber_desc_t front_desc;
	ber_pkg::ber_desc_t head_desc;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_nonempty;

	ber_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value_bits (value_bits),
		.q_full     (q_full),
		.push       (push),
		.desc       (front_desc)
	);

	// The queue lets the front keep taking items while the back end is still
	// streaming a long encoding.
	ber_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (front_desc),
		.pop      (pop),
		.rdata    (head_desc),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	// The back end walks header, exponent and mantissa octets, or the single
	// octet of a special value, one per cycle, and loads the next descriptor in
	// the cycle of the final octet so queued items follow each other with no gap.
	ber_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (head_desc),
		.pop        (pop),
		.valid      (valid),
		.out_byte   (out_byte),
		.last       (last),
		.empty_res  (empty_res)
	);

endmodule
